>>> rtl/core/ring_node_frame_receiver_macros.svh
// Assertion macros for the ring node frame receiver
`ifndef RING_NODE_FRAME_RECEIVER_MACROS_SVH
`define RING_NODE_FRAME_RECEIVER_MACROS_SVH

`ifndef NO_ASSERTIONS

`define RNFR_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

`define RNFR_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`else

`define RNFR_ASSERT_NOW(name, ante, cons, msg)

`define RNFR_ASSERT_NEXT(name, ante, cons, msg)

`endif

`endif

>>> rtl/core/rnfr_pkg.sv
// Types, codes and helper functions shared by the ring node frame receiver
package rnfr_pkg;

  typedef struct packed {
    logic [1:0] command;
    logic [7:0] rx_byte;
    logic [7:0] tick_ms;
  } in_word_t;

  typedef struct packed {
    logic [3:0] action;
    logic [7:0] drive_value;
    logic [7:0] subcommand;
    logic [7:0] reply_value;
    logic       forward_frame;
    logic       echo_enable;
    logic [7:0] node_address;
  } out_word_t;

  typedef enum logic [1:0] {
    AGE_KEEP,
    AGE_CLEAR,
    AGE_LOAD
  } age_op_t;

  typedef struct packed {
    logic [7:0] first_payload;
    logic [7:0] second_payload;
    logic [7:0] third_payload;
    logic [7:0] broadcast_byte;
    logic [6:0] frame_length;
    logic [7:0] own_address;
    logic       store_forward_mode;
    logic       start_mode;
  } frame_info_t;

  typedef struct packed {
    logic [3:0] action;
    logic [7:0] drive_value;
    logic [7:0] subcommand;
    logic [7:0] reply_value;
    logic       forward_frame;
    logic       sfm_write;
    logic       sfm_value;
    logic       addr_write;
    logic [7:0] new_address;
    age_op_t    age_op;
  } decode_t;

  localparam logic [1:0] CMD_BYTE     = 2'd0;
  localparam logic [1:0] CMD_TICK     = 2'd1;
  localparam logic [1:0] CMD_OVERFLOW = 2'd2;

  localparam logic [3:0] ACT_NONE      = 4'd0;
  localparam logic [3:0] ACT_STORE_FWD = 4'd1;
  localparam logic [3:0] ACT_CUT_THRU  = 4'd2;
  localparam logic [3:0] ACT_ADDR      = 4'd3;
  localparam logic [3:0] ACT_BCAST     = 4'd4;
  localparam logic [3:0] ACT_ALL_STOP  = 4'd5;
  localparam logic [3:0] ACT_DRIVE     = 4'd6;
  localparam logic [3:0] ACT_STOP      = 4'd7;
  localparam logic [3:0] ACT_STATUS    = 4'd8;
  localparam logic [3:0] ACT_LOADER    = 4'd9;
  localparam logic [3:0] ACT_UNKNOWN   = 4'd10;
  localparam logic [3:0] ACT_WATCHDOG  = 4'd11;

  localparam logic [7:0] OP_STORE_FWD = 8'h01;
  localparam logic [7:0] OP_CUT_THRU  = 8'h02;
  localparam logic [7:0] OP_ADDR      = 8'h03;
  localparam logic [7:0] OP_BCAST     = 8'h11;
  localparam logic [7:0] OP_ALL_STOP  = 8'h12;
  localparam logic [7:0] OP_GROUP     = 8'h20;

  localparam logic [7:0] SUB_DRIVE  = 8'h01;
  localparam logic [7:0] SUB_STOP   = 8'h02;
  localparam logic [7:0] SUB_STATUS = 8'h03;
  localparam logic [7:0] SUB_LOADER = 8'h1B;

  localparam logic [6:0] ADDR_MIN_LEN = 7'd2;
  localparam logic [6:0] DRIVE_LEN    = 7'd3;
  localparam logic [6:0] BCAST_LEN    = 7'd10;

  localparam logic [7:0] PREAMBLE0  = 8'hA5;
  localparam logic [7:0] PREAMBLE1  = 8'h5A;
  localparam logic [7:0] UNASSIGNED = 8'hFF;
  localparam logic [15:0] CRC_INIT  = 16'hFFFF;
  localparam logic [15:0] CRC_POLY  = 16'h1021;
  localparam logic [15:0] AGE_MAX   = 16'hFFFF;

  localparam logic [15:0] TIMEOUT_RESET_MS  = 16'd20;
  localparam logic [15:0] WATCHDOG_RESET_MS = 16'd100;

  localparam logic CFG_TIMEOUT  = 1'b0;
  localparam logic CFG_WATCHDOG = 1'b1;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

  function automatic logic [15:0] sat_add(input logic [15:0] a, input logic [7:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {9'd0, b};
    return s[16] ? AGE_MAX : s[15:0];
  endfunction

endpackage

>>> rtl/core/ring_node_frame_receiver.sv
// Ring node frame receiver: preamble hunt, CRC check, command decode, timers
// The input reg holds each accepted word; byte-wide CRC and decode sit between it and the
// result reg. Throughput: one word per cycle while the result is not stalled.
// Every input word gives exactly one result word; a stalled result holds one word back.
// Reset (rst, synchronous): receiver hunts for A5, address unassigned, cut-through mode,
// timeout 20 ms, watchdog 100 ms with the watchdog already expired.
module ring_node_frame_receiver #(
  parameter int MAX_PAYLOAD_BYTES = 64,
  parameter int NODE_COUNT        = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  rnfr_pkg::in_word_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output rnfr_pkg::out_word_t out_data,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [15:0]         cfg_data
);

  `include "ring_node_frame_receiver_macros.svh"

  localparam logic [7:0] MaxLen = 8'(MAX_PAYLOAD_BYTES);

  typedef enum logic [1:0] {
    PH_SCAN0 = 2'd0,
    PH_SCAN1 = 2'd1,
    PH_BODY  = 2'd2
  } phase_t;

  logic                sel_timeout;
  logic [15:0]         timeout_ms;
  logic [15:0]         watchdog_ms;

  logic                in_valid_q;
  rnfr_pkg::in_word_t  in_q;
  logic                adv;

  phase_t      phase, phase_next;
  logic [6:0]  byte_count, byte_count_next;
  logic [6:0]  frame_length, frame_length_next;
  logic [15:0] running_crc, running_crc_next;
  logic [7:0]  crc_high_byte, crc_high_byte_next;
  logic [7:0]  first_payload, first_payload_next;
  logic [7:0]  second_payload, second_payload_next;
  logic [7:0]  third_payload, third_payload_next;
  logic [7:0]  broadcast_byte, broadcast_byte_next;
  logic [7:0]  own_address, own_address_next;
  logic        store_forward_mode, store_forward_mode_next;
  logic        start_mode, start_mode_next;
  logic [15:0] receive_age, receive_age_next;
  logic [15:0] command_age, command_age_next;

  rnfr_pkg::frame_info_t info;
  rnfr_pkg::decode_t     dec;
  rnfr_pkg::out_word_t   res;

  logic [7:0]  v;
  logic [6:0]  pos;
  logic        frame_drop;

  assign sel_timeout = (cfg_index == rnfr_pkg::CFG_TIMEOUT);

  assign info = '{
    first_payload:      first_payload,
    second_payload:     second_payload,
    third_payload:      third_payload,
    broadcast_byte:     broadcast_byte,
    frame_length:       frame_length,
    own_address:        own_address,
    store_forward_mode: store_forward_mode,
    start_mode:         start_mode
  };

  rnfr_decode #(
    .NODE_COUNT(NODE_COUNT)
  ) u_decode (
    .info(info),
    .dec (dec)
  );

  assign adv      = in_valid_q && (!out_valid || out_ready);
  assign in_ready = !in_valid_q || adv;
  assign v        = in_q.rx_byte;
  assign pos      = byte_count - 7'd1;

  always_comb begin
    phase_next              = phase;
    byte_count_next         = byte_count;
    frame_length_next       = frame_length;
    running_crc_next        = running_crc;
    crc_high_byte_next      = crc_high_byte;
    first_payload_next      = first_payload;
    second_payload_next     = second_payload;
    third_payload_next      = third_payload;
    broadcast_byte_next     = broadcast_byte;
    own_address_next        = own_address;
    store_forward_mode_next = store_forward_mode;
    start_mode_next         = start_mode;
    receive_age_next        = receive_age;
    command_age_next        = command_age;
    frame_drop              = 1'b0;
    res                     = '0;

    unique case (in_q.command)
      rnfr_pkg::CMD_BYTE: begin
        unique case (phase)
          PH_SCAN1: begin
            if (v == rnfr_pkg::PREAMBLE1) begin
              phase_next          = PH_BODY;
              byte_count_next     = 7'd0;
              frame_length_next   = 7'd0;
              running_crc_next    = rnfr_pkg::CRC_INIT;
              broadcast_byte_next = 8'd0;
              start_mode_next     = store_forward_mode;
            end else if (v != rnfr_pkg::PREAMBLE0) begin
              phase_next = PH_SCAN0;
            end
          end
          PH_BODY: begin
            priority if (byte_count == 7'd0) begin
              if (v == 8'd0 || v > MaxLen) begin
                frame_drop = 1'b1;
              end else begin
                frame_length_next = v[6:0];
                running_crc_next  = rnfr_pkg::crc_byte(rnfr_pkg::CRC_INIT, v);
                byte_count_next   = 7'd1;
              end
            end else if (byte_count <= frame_length) begin
              if (pos == 7'd0) first_payload_next = v;
              if (pos == 7'd1) second_payload_next = v;
              if (pos == 7'd2) third_payload_next = v;
              if ({2'b00, pos} == {1'b0, own_address} + 9'd2) broadcast_byte_next = v;
              running_crc_next = rnfr_pkg::crc_byte(running_crc, v);
              byte_count_next  = byte_count + 7'd1;
            end else if (byte_count == frame_length + 7'd1) begin
              crc_high_byte_next = v;
              byte_count_next    = byte_count + 7'd1;
            end else begin
              if (running_crc == {crc_high_byte, v}) begin
                res.action        = dec.action;
                res.drive_value   = dec.drive_value;
                res.subcommand    = dec.subcommand;
                res.reply_value   = dec.reply_value;
                res.forward_frame = dec.forward_frame;
                if (dec.sfm_write) store_forward_mode_next = dec.sfm_value;
                if (dec.addr_write) own_address_next = dec.new_address;
                unique case (dec.age_op)
                  rnfr_pkg::AGE_CLEAR: command_age_next = 16'd0;
                  rnfr_pkg::AGE_LOAD:  command_age_next = watchdog_ms;
                  default:             command_age_next = command_age;
                endcase
              end
              frame_drop = 1'b1;
            end
          end
          default: begin
            phase_next = (v == rnfr_pkg::PREAMBLE0) ? PH_SCAN1 : PH_SCAN0;
          end
        endcase
      end
      rnfr_pkg::CMD_TICK: begin
        if (phase == PH_SCAN1 || phase == PH_BODY) begin
          receive_age_next = rnfr_pkg::sat_add(receive_age, in_q.tick_ms);
          if (receive_age_next >= timeout_ms) frame_drop = 1'b1;
        end else begin
          phase_next = PH_SCAN0;
        end
        if (command_age < watchdog_ms) begin
          command_age_next = rnfr_pkg::sat_add(command_age, in_q.tick_ms);
          if (command_age_next >= watchdog_ms) res.action = rnfr_pkg::ACT_WATCHDOG;
        end
      end
      rnfr_pkg::CMD_OVERFLOW: begin
        frame_drop = 1'b1;
      end
      default: begin
      end
    endcase

    if (frame_drop) begin
      phase_next        = PH_SCAN0;
      byte_count_next   = 7'd0;
      frame_length_next = 7'd0;
      running_crc_next  = rnfr_pkg::CRC_INIT;
      receive_age_next  = 16'd0;
    end

    res.echo_enable  = !store_forward_mode_next;
    res.node_address = own_address_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ms         <= rnfr_pkg::TIMEOUT_RESET_MS;
      watchdog_ms        <= rnfr_pkg::WATCHDOG_RESET_MS;
      in_valid_q         <= 1'b0;
      out_valid          <= 1'b0;
      phase              <= PH_SCAN0;
      byte_count         <= 7'd0;
      frame_length       <= 7'd0;
      running_crc        <= rnfr_pkg::CRC_INIT;
      crc_high_byte      <= 8'd0;
      first_payload      <= 8'd0;
      second_payload     <= 8'd0;
      third_payload      <= 8'd0;
      broadcast_byte     <= 8'd0;
      own_address        <= rnfr_pkg::UNASSIGNED;
      store_forward_mode <= 1'b0;
      start_mode         <= 1'b0;
      receive_age        <= 16'd0;
      command_age        <= rnfr_pkg::WATCHDOG_RESET_MS;
    end else begin
      if (cfg_we) begin
        if (sel_timeout) timeout_ms <= cfg_data;
        else watchdog_ms <= cfg_data;
      end
      if (in_valid && in_ready) begin
        in_valid_q <= 1'b1;
      end else if (adv) begin
        in_valid_q <= 1'b0;
      end
      if (adv) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (adv) begin
        phase              <= phase_next;
        byte_count         <= byte_count_next;
        frame_length       <= frame_length_next;
        running_crc        <= running_crc_next;
        crc_high_byte      <= crc_high_byte_next;
        first_payload      <= first_payload_next;
        second_payload     <= second_payload_next;
        third_payload      <= third_payload_next;
        broadcast_byte     <= broadcast_byte_next;
        own_address        <= own_address_next;
        store_forward_mode <= store_forward_mode_next;
        start_mode         <= start_mode_next;
        receive_age        <= receive_age_next;
        command_age        <= command_age_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) in_q <= in_data;
    if (adv) out_data <= res;
  end

  `RNFR_ASSERT_NEXT(a_addr_sticky, own_address != rnfr_pkg::UNASSIGNED,
    $stable(own_address), "assigned node address changed")
  `RNFR_ASSERT_NEXT(a_adv_result, adv, out_valid, "advanced word produced no result")
  `RNFR_ASSERT_NOW(a_stall_cause, !in_ready, in_valid_q && out_valid && !out_ready,
    "input stalled without a blocked result")
  `RNFR_ASSERT_NOW(a_count_bound, phase == PH_BODY,
    {1'b0, byte_count} <= {1'b0, frame_length} + 8'd2, "byte count ran past frame end")

endmodule

>>> rtl/core/rnfr_decode.sv
// Command decoder for a frame whose check matched
module rnfr_decode #(
  parameter int NODE_COUNT = 8
) (
  input  rnfr_pkg::frame_info_t info,
  output rnfr_pkg::decode_t     dec
);

  localparam logic [7:0] NodeLimit = 8'(NODE_COUNT);
  localparam logic [8:0] GroupEnd  = 9'(32 + NODE_COUNT);

  logic [7:0] c;
  logic       group_hit;

  assign c = info.first_payload;
  assign group_hit = (c >= rnfr_pkg::OP_GROUP) && ({1'b0, c} < GroupEnd)
                   && ({4'd0, c[3:0]} == info.own_address)
                   && (info.frame_length >= rnfr_pkg::ADDR_MIN_LEN);

  always_comb begin
    dec = '0;
    dec.age_op = rnfr_pkg::AGE_KEEP;
    priority if (c == rnfr_pkg::OP_STORE_FWD || c == rnfr_pkg::OP_CUT_THRU) begin
      dec.sfm_write     = 1'b1;
      dec.sfm_value     = (c == rnfr_pkg::OP_STORE_FWD);
      dec.action        = (c == rnfr_pkg::OP_STORE_FWD) ? rnfr_pkg::ACT_STORE_FWD
                                                        : rnfr_pkg::ACT_CUT_THRU;
      dec.forward_frame = info.start_mode;
    end else if (c == rnfr_pkg::OP_ADDR && info.frame_length >= rnfr_pkg::ADDR_MIN_LEN) begin
      if (info.second_payload < NodeLimit) begin
        dec.addr_write  = (info.own_address == rnfr_pkg::UNASSIGNED);
        dec.new_address = info.second_payload;
        dec.action      = rnfr_pkg::ACT_ADDR;
        dec.reply_value = info.second_payload + 8'd1;
      end
    end else if (c == rnfr_pkg::OP_BCAST && info.frame_length == rnfr_pkg::BCAST_LEN
                 && info.own_address < NodeLimit) begin
      dec.action      = rnfr_pkg::ACT_BCAST;
      dec.drive_value = info.broadcast_byte;
      dec.age_op      = rnfr_pkg::AGE_CLEAR;
    end else if (c == rnfr_pkg::OP_ALL_STOP) begin
      dec.action = rnfr_pkg::ACT_ALL_STOP;
      dec.age_op = rnfr_pkg::AGE_LOAD;
    end else if (group_hit) begin
      dec.subcommand = info.second_payload;
      priority if (info.second_payload == rnfr_pkg::SUB_DRIVE
                   && info.frame_length == rnfr_pkg::DRIVE_LEN) begin
        dec.action      = rnfr_pkg::ACT_DRIVE;
        dec.drive_value = info.third_payload;
        dec.age_op      = rnfr_pkg::AGE_CLEAR;
      end else if (info.second_payload == rnfr_pkg::SUB_STOP) begin
        dec.action = rnfr_pkg::ACT_STOP;
      end else if (info.second_payload == rnfr_pkg::SUB_STATUS) begin
        dec.action = rnfr_pkg::ACT_STATUS;
      end else if (info.second_payload == rnfr_pkg::SUB_LOADER) begin
        dec.action = rnfr_pkg::ACT_LOADER;
      end else begin
        dec.action = rnfr_pkg::ACT_UNKNOWN;
      end
    end else if (info.store_forward_mode) begin
      dec.forward_frame = 1'b1;
    end
  end

endmodule

>>> tb/ring_node_frame_receiver_check.sv
// Result predictor and scoreboard for the ring node frame receiver
module ring_node_frame_receiver_check #(
  parameter int MAX_PAYLOAD_BYTES = 64,
  parameter int NODE_COUNT        = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                in_ready,
  input  rnfr_pkg::in_word_t  in_data,
  input  logic                out_valid,
  input  logic                out_ready,
  input  rnfr_pkg::out_word_t out_data,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [15:0]         cfg_data,
  output int                  mismatch_count,
  output int                  words_pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import rnfr_pkg::*;

  typedef enum logic [1:0] {
    HUNT_A5,
    HUNT_5A,
    IN_FRAME
  } hunt_t;

  logic [15:0] timeout_ms;
  logic [15:0] watchdog_lim;

  hunt_t       hunt;
  logic [6:0]  pos_count;
  logic [6:0]  frame_len;
  logic [15:0] crc_acc;
  logic [7:0]  crc_hi;
  logic [7:0]  pay0;
  logic [7:0]  pay1;
  logic [7:0]  pay2;
  logic [7:0]  bcast_byte;
  logic [7:0]  my_addr;
  logic        sf_mode;
  logic        sf_at_start;
  logic [15:0] rx_age;
  logic [15:0] drive_age;

  out_word_t expected_q[$];

  function automatic logic [15:0] crc_update(logic [15:0] acc, logic [7:0] b);
    logic [15:0] r;
    r = acc;
    for (int i = 7; i >= 0; i--) begin
      if (r[15] ^ b[i]) r = {r[14:0], 1'b0} ^ CRC_POLY;
      else r = {r[14:0], 1'b0};
    end
    return r;
  endfunction

  function automatic logic [15:0] age_add(logic [15:0] a, logic [7:0] d);
    int s;
    s = a + d;
    return (s > 32'hFFFF) ? AGE_MAX : 16'(s);
  endfunction

  function automatic void restart_receiver();
    hunt = HUNT_A5;
    pos_count = '0;
    frame_len = '0;
    crc_acc = CRC_INIT;
    rx_age = '0;
  endfunction

  function automatic out_word_t decode_frame(out_word_t o);
    out_word_t r;
    r = o;
    if (pay0 == OP_STORE_FWD || pay0 == OP_CUT_THRU) begin
      sf_mode = (pay0 == OP_STORE_FWD);
      r.action = (pay0 == OP_STORE_FWD) ? ACT_STORE_FWD : ACT_CUT_THRU;
      r.forward_frame = sf_at_start;
    end else if (pay0 == OP_ADDR && frame_len >= ADDR_MIN_LEN) begin
      if (pay1 < NODE_COUNT) begin
        if (my_addr == UNASSIGNED) my_addr = pay1;
        r.action = ACT_ADDR;
        r.reply_value = pay1 + 8'd1;
      end
    end else if (pay0 == OP_BCAST && frame_len == BCAST_LEN && my_addr < NODE_COUNT) begin
      r.action = ACT_BCAST;
      r.drive_value = bcast_byte;
      drive_age = '0;
    end else if (pay0 == OP_ALL_STOP) begin
      r.action = ACT_ALL_STOP;
      drive_age = watchdog_lim;
    end else if (pay0 >= OP_GROUP && pay0 < OP_GROUP + NODE_COUNT &&
                 {4'h0, pay0[3:0]} == my_addr && frame_len >= ADDR_MIN_LEN) begin
      r.subcommand = pay1;
      if (pay1 == SUB_DRIVE && frame_len == DRIVE_LEN) begin
        r.action = ACT_DRIVE;
        r.drive_value = pay2;
        drive_age = '0;
      end else if (pay1 == SUB_STOP) begin
        r.action = ACT_STOP;
      end else if (pay1 == SUB_STATUS) begin
        r.action = ACT_STATUS;
      end else if (pay1 == SUB_LOADER) begin
        r.action = ACT_LOADER;
      end else begin
        r.action = ACT_UNKNOWN;
      end
    end else if (sf_mode) begin
      r.forward_frame = 1'b1;
    end
    return r;
  endfunction

  function automatic out_word_t take_rx_byte(logic [7:0] v);
    out_word_t r;
    int idx;
    r = '0;
    case (hunt)
      HUNT_5A: begin
        if (v == PREAMBLE1) begin
          hunt = IN_FRAME;
          pos_count = '0;
          frame_len = '0;
          crc_acc = CRC_INIT;
          bcast_byte = '0;
          sf_at_start = sf_mode;
        end else if (v != PREAMBLE0) begin
          hunt = HUNT_A5;
        end
      end
      IN_FRAME: begin
        if (pos_count == 0) begin
          if (v == 8'd0 || v > MAX_PAYLOAD_BYTES) begin
            restart_receiver();
          end else begin
            frame_len = v[6:0];
            crc_acc = crc_update(CRC_INIT, v);
            pos_count = 7'd1;
          end
        end else if (pos_count <= frame_len) begin
          idx = pos_count - 1;
          if (idx == 0) pay0 = v;
          if (idx == 1) pay1 = v;
          if (idx == 2) pay2 = v;
          if (idx == my_addr + 2) bcast_byte = v;
          crc_acc = crc_update(crc_acc, v);
          pos_count++;
        end else if (pos_count == frame_len + 1) begin
          crc_hi = v;
          pos_count++;
        end else begin
          if (crc_acc == {crc_hi, v}) r = decode_frame(r);
          restart_receiver();
        end
      end
      default: begin
        hunt = (v == PREAMBLE0) ? HUNT_5A : HUNT_A5;
      end
    endcase
    return r;
  endfunction

  function automatic out_word_t predict_result(in_word_t w);
    out_word_t r;
    r = '0;
    if (w.command == CMD_BYTE) begin
      r = take_rx_byte(w.rx_byte);
    end else if (w.command == CMD_TICK) begin
      if (hunt != HUNT_A5) begin
        rx_age = age_add(rx_age, w.tick_ms);
        if (rx_age >= timeout_ms) restart_receiver();
      end
      if (drive_age < watchdog_lim) begin
        drive_age = age_add(drive_age, w.tick_ms);
        if (drive_age >= watchdog_lim) r.action = ACT_WATCHDOG;
      end
    end else if (w.command == CMD_OVERFLOW) begin
      restart_receiver();
    end
    r.echo_enable = !sf_mode;
    r.node_address = my_addr;
    return r;
  endfunction

  function automatic void compare_field(string name, logic [7:0] want_v, logic [7:0] got_v);
    if (want_v !== got_v) begin
      $error("%s: expected %0d, got %0d", name, want_v, got_v);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk) begin : watch
    out_word_t want;
    if (rst) begin
      timeout_ms = TIMEOUT_RESET_MS;
      watchdog_lim = WATCHDOG_RESET_MS;
      restart_receiver();
      crc_hi = '0;
      pay0 = '0;
      pay1 = '0;
      pay2 = '0;
      bcast_byte = '0;
      my_addr = UNASSIGNED;
      sf_mode = 1'b0;
      sf_at_start = 1'b0;
      drive_age = WATCHDOG_RESET_MS;
      expected_q.delete();
      words_pending <= 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_TIMEOUT) timeout_ms = cfg_data;
        else watchdog_lim = cfg_data;
      end
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          $error("result word with nothing outstanding: %p", out_data);
          mismatch_count++;
        end else begin
          want = expected_q.pop_front();
          compare_field("action", want.action, out_data.action);
          compare_field("drive_value", want.drive_value, out_data.drive_value);
          compare_field("subcommand", want.subcommand, out_data.subcommand);
          compare_field("reply_value", want.reply_value, out_data.reply_value);
          compare_field("forward_frame", want.forward_frame, out_data.forward_frame);
          compare_field("echo_enable", want.echo_enable, out_data.echo_enable);
          compare_field("node_address", want.node_address, out_data.node_address);
        end
      end
      if (in_valid && in_ready) expected_q.push_back(predict_result(in_data));
      words_pending <= expected_q.size();
    end
  end

endmodule

>>> tb/ring_node_frame_receiver_tb.sv
// Top of the ring node frame receiver testbench: clock, reset, frame traffic and verdict
module ring_node_frame_receiver_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import rnfr_pkg::*;

  localparam int PAYLOAD_MAX = 64;
  localparam int NODES = 8;
  localparam int HOLD_CYCLES = 300;
  localparam int RUN_LIMIT_NS = 6_000_000;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  in_word_t    in_data;
  logic        out_valid;
  logic        out_ready;
  out_word_t   out_data;
  logic        cfg_we;
  logic        cfg_index;
  logic [15:0] cfg_data;

  int mismatch_count;
  int words_pending;
  int words_sent = 0;
  int burst_left = 0;
  int frame_seq = 0;
  int hold_req = 0;
  logic [7:0] node_addr;
  logic [7:0] payload_q[$];

  ring_node_frame_receiver #(
    .MAX_PAYLOAD_BYTES(PAYLOAD_MAX),
    .NODE_COUNT(NODES)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  ring_node_frame_receiver_check #(
    .MAX_PAYLOAD_BYTES(PAYLOAD_MAX),
    .NODE_COUNT(NODES)
  ) action_check (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .mismatch_count(mismatch_count),
    .words_pending(words_pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #(RUN_LIMIT_NS);
    $display("status: fail");
    $finish;
  end

  initial begin : result_sink
    int cyc;
    int mode;
    int seen;
    cyc = 0;
    mode = 0;
    seen = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req != seen) begin
        seen = hold_req;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      if (cyc % 50 == 0) mode = $urandom_range(0, 3);
      cyc++;
      case (mode)
        0: out_ready <= 1'b1;
        1: out_ready <= ($urandom_range(0, 1) == 0);
        2: out_ready <= ($urandom_range(0, 3) == 0);
        default: out_ready <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  function automatic in_word_t make_word(logic [1:0] cmd, logic [7:0] rx, logic [7:0] el);
    in_word_t w;
    w.command = cmd;
    w.rx_byte = rx;
    w.tick_ms = el;
    return w;
  endfunction

  task automatic send_word(input in_word_t w);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 4);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(60, 150)
                                                : $urandom_range(1, 16);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (!in_ready);
    if (w.command != CMD_UNUSED) words_sent++;
  endtask

  task automatic send_byte(input logic [7:0] v);
    send_word(make_word(CMD_BYTE, v, 8'($urandom)));
  endtask

  task automatic send_tick(input logic [7:0] ms);
    send_word(make_word(CMD_TICK, 8'($urandom), ms));
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (words_pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic configure(input logic [15:0] timeout_v, input logic [15:0] watchdog_v);
    wait_idle();
    cfg_we <= 1'b1;
    cfg_index <= CFG_TIMEOUT;
    cfg_data <= timeout_v;
    @(posedge clk);
    cfg_index <= CFG_WATCHDOG;
    cfg_data <= watchdog_v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic send_frame(input bit jitter, input bit corrupt);
    logic [15:0] crc;
    logic [7:0] len;
    len = 8'(payload_q.size());
    crc = crc_byte(CRC_INIT, len);
    foreach (payload_q[i]) crc = crc_byte(crc, payload_q[i]);
    if (corrupt) crc = crc ^ 16'($urandom_range(1, 16'hFFFF));
    send_byte(PREAMBLE0);
    send_byte(PREAMBLE1);
    send_byte(len);
    foreach (payload_q[i]) begin
      if (jitter && $urandom_range(0, 9) == 0) send_tick(8'($urandom_range(0, 2)));
      send_byte(payload_q[i]);
    end
    send_byte(crc[15:8]);
    send_byte(crc[7:0]);
  endtask

  task automatic build_frame(input int kind);
    int extra;
    logic [7:0] target;
    payload_q.delete();
    extra = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
    target = ($urandom_range(0, 4) != 0) ? node_addr : 8'($urandom_range(0, 15));
    case (kind)
      0: payload_q.push_back(OP_STORE_FWD);
      1: payload_q.push_back(OP_CUT_THRU);
      2: begin
        payload_q.push_back(OP_ADDR);
        payload_q.push_back(8'($urandom_range(0, 15)));
      end
      3: begin
        payload_q.push_back(OP_BCAST);
        repeat (($urandom_range(0, 5) == 0) ? $urandom_range(8, 10) : 9)
          payload_q.push_back(8'($urandom));
        if ($urandom_range(0, 3) != 0) extra = 0;
      end
      4: payload_q.push_back(OP_ALL_STOP);
      5, 6, 7, 8, 9: begin
        payload_q.push_back(8'(OP_GROUP + target));
        case (kind)
          5: begin
            payload_q.push_back(SUB_DRIVE);
            payload_q.push_back(8'($urandom));
            if ($urandom_range(0, 3) != 0) extra = 0;
          end
          6: payload_q.push_back(SUB_STOP);
          7: payload_q.push_back(SUB_STATUS);
          8: payload_q.push_back(SUB_LOADER);
          default: payload_q.push_back(8'($urandom));
        endcase
      end
      default: begin
        payload_q.push_back(8'($urandom));
        repeat ($urandom_range(0, 3)) payload_q.push_back(8'($urandom));
      end
    endcase
    repeat (extra) payload_q.push_back(8'($urandom));
    if ($urandom_range(0, 29) == 0)
      while (payload_q.size() < PAYLOAD_MAX) payload_q.push_back(8'($urandom));
  endtask

  task automatic line_noise();
    int n;
    case ($urandom_range(0, 5))
      0: repeat ($urandom_range(1, 6)) send_byte(8'($urandom));
      1: begin
        repeat ($urandom_range(1, 3)) send_byte(PREAMBLE0);
        send_byte(PREAMBLE1);
        send_byte(($urandom_range(0, 2) == 0) ? 8'd0 : 8'($urandom_range(PAYLOAD_MAX + 1, 255)));
      end
      2: begin
        n = $urandom_range(1, 8);
        send_byte(PREAMBLE0);
        send_byte(PREAMBLE1);
        send_byte(8'(n));
        repeat ($urandom_range(0, n)) send_byte(8'($urandom));
        case ($urandom_range(0, 2))
          0: send_word(make_word(CMD_OVERFLOW, 8'($urandom), 8'($urandom)));
          1: send_tick(8'hFF);
          default: ;
        endcase
      end
      3: send_word(make_word(CMD_OVERFLOW, 8'($urandom), 8'($urandom)));
      4: send_word(make_word(CMD_UNUSED, 8'($urandom), 8'($urandom)));
      default: begin
        send_byte(PREAMBLE0);
        send_byte(8'($urandom_range(0, 8'h59)));
      end
    endcase
  endtask

  task automatic random_traffic(input int n_words);
    int stop_at;
    int pick;
    int kind;
    stop_at = words_sent + n_words;
    while (words_sent < stop_at) begin
      pick = $urandom_range(0, 19);
      if (pick < 13) begin
        kind = (frame_seq < 12) ? frame_seq : $urandom_range(0, 11);
        frame_seq++;
        build_frame(kind);
        send_frame(1'b1, $urandom_range(0, 9) == 0);
      end else if (pick < 17) begin
        repeat ($urandom_range(1, 4))
          send_tick(($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 30)));
      end else begin
        line_noise();
      end
    end
  endtask

  task automatic directed_words();
    send_word(make_word(CMD_OVERFLOW, 8'hFF, 8'hFF));
    send_word(make_word(CMD_UNUSED, 8'h00, 8'h00));
    send_tick(8'h00);
    send_tick(8'hFF);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(PREAMBLE0);
    send_byte(PREAMBLE0);
    send_byte(PREAMBLE1);
    send_byte(8'h00);
    send_byte(PREAMBLE0);
    send_byte(PREAMBLE1);
    send_byte(8'(PAYLOAD_MAX + 1));
    payload_q.delete();
    payload_q.push_back(OP_ADDR);
    payload_q.push_back(8'(NODES + 1));
    send_frame(1'b0, 1'b0);
    payload_q.delete();
    payload_q.push_back(OP_ADDR);
    payload_q.push_back(node_addr);
    send_frame(1'b0, 1'b0);
  endtask

  initial begin
    rst <= 1'b1;
    in_valid <= 1'b0;
    in_data <= '0;
    cfg_we <= 1'b0;
    cfg_index <= CFG_TIMEOUT;
    cfg_data <= '0;
    node_addr = 8'($urandom_range(0, NODES - 1));
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    repeat (2) @(posedge clk);

    directed_words();
    random_traffic(40);

    configure(16'd1, 16'd1);
    random_traffic(30);

    // hold: drive clears the watchdog, then both ages saturate on one long partial frame
    configure(AGE_MAX, AGE_MAX);
    payload_q.delete();
    payload_q.push_back(8'(OP_GROUP + node_addr));
    payload_q.push_back(SUB_DRIVE);
    payload_q.push_back(8'($urandom));
    send_frame(1'b0, 1'b0);
    send_byte(PREAMBLE0);
    send_byte(PREAMBLE1);
    send_byte(8'd5);
    repeat (260) send_tick(8'hFF);
    random_traffic(25);

    configure(16'd0, 16'd0);
    random_traffic(25);

    configure(16'($urandom_range(5, 300)), 16'($urandom_range(10, 2000)));
    hold_req <= hold_req + 1;
    random_traffic(55);

    configure(TIMEOUT_RESET_MS, WATCHDOG_RESET_MS);
    random_traffic(25);

    wait_idle();
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
